### sv/ptt_pkg.sv
// Shared types, constants and codes of the periodic action timer table.
package ptt_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam int TIME_W = 48;
  localparam int CFG_AW = 3;

  localparam logic [TIME_W-1:0] US_PER_MS = TIME_W'(1000);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_FIRE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ACK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0]       id;
    logic [31:0]       interval;
    logic [31:0]       life;
    logic              unlimited;
    logic              stop_flag;
    logic [TIME_W-1:0] process;
    logic [TIME_W-1:0] phase;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/ptt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ptt_cfg.sv
// APB-style configuration register block holding the elapsed-time clamp.
module ptt_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ptt_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [31:0]               max_elapsed_us
);
  import ptt_pkg::*;

  logic [31:0] max_el_r;
  logic        sel0;

  // Register 0 sits at byte address 0; any other word is unused.
  assign sel0 = (paddr[CFG_AW-1:2] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_el_r <= 32'hFFFF_FFFF;
    end else if (psel && penable && pwrite && sel0) begin
      max_el_r <= pwdata;
    end
  end

  assign prdata = sel0 ? max_el_r : 32'd0;
  assign pready = 1'b1;
  assign max_elapsed_us = max_el_r;

endmodule

### sv/periodic_action_timer_table.sv
// Top level of the periodic action timer table: command sequencer around the entry RAM.
// A start writes its entry unless the table is full and then acknowledges; the unused code
// goes straight to the acknowledge. A stop reads and compares each entry in turn until the id
// is found or the table ends; a tick takes each live entry through the read, multiply and
// evaluate steps around the single entry RAM port, then gives an end event. Throughput: one
// item at a time. Reset (synchronous, rst_n low) empties the table and sets the clamp to all ones.
module periodic_action_timer_table (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_cmd,
  input  logic [31:0]                in_timer_id,
  input  logic [31:0]                in_interval_ms,
  input  logic [31:0]                in_life_ms,
  input  logic                       in_life_unlimited,
  input  logic [31:0]                in_elapsed_us,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output logic [1:0]                 out_status,
  output logic [31:0]                out_fired_id,
  output logic [31:0]                out_clamped_elapsed_us,
  output logic [47:0]                out_process_us,
  output logic                       out_last,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptt_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ptt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TRD, S_TMUL, S_TEVAL, S_TEND, S_START, S_SRD, S_SCMP, S_ACK
  } state_t;

  logic [31:0] max_el;

  ptt_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .max_elapsed_us (max_el)
  );

  // The entry RAM. Live entries always occupy slots 0 .. count-1, so the
  // fill count stands in for per-slot valid bits.
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t             mem_q;

  ptt_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_ENTRIES), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );
  assign mem_q = entry_t'(mem_rdata);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;    // read pointer of a walk
  logic [CNT_W-1:0]  keep_r, keep_nxt;  // compaction write pointer of a tick
  logic [31:0]       id_r, id_nxt;
  logic [31:0]       ivl_r, ivl_nxt;
  logic [31:0]       life_r, life_nxt;
  logic              unl_r, unl_nxt;
  logic [31:0]       el_r, el_nxt;
  status_t           ack_st_r, ack_st_nxt;
  // Registered products and sums of the entry under evaluation.
  entry_t            rec_r, rec_nxt;
  logic [TIME_W-1:0] life_k_r, life_k_nxt;
  logic [TIME_W-1:0] ivl_k_r, ivl_k_nxt;
  logic [TIME_W-1:0] proc_s_r, proc_s_nxt;
  logic [TIME_W-1:0] phase_s_r, phase_s_nxt;
  // Output register.
  logic              ov_r, ov_nxt;
  kind_t             ok_r, ok_nxt;
  status_t           os_r, os_nxt;
  logic [31:0]       oid_r, oid_nxt;
  logic [31:0]       oel_r, oel_nxt;
  logic [TIME_W-1:0] opr_r, opr_nxt;
  logic              olast_r, olast_nxt;

  logic              out_free;
  logic              in_acc;
  logic [TIME_W:0]   psum, hsum;
  logic              drop, fire;
  entry_t            upd;

  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;

  assign psum = {1'b0, mem_q.process} + (TIME_W + 1)'(el_r);
  assign hsum = {1'b0, mem_q.phase} + (TIME_W + 1)'(el_r);

  // Lifetime and interval are compared in microseconds, which avoids any divide.
  assign drop = rec_r.stop_flag || (!rec_r.unlimited && (rec_r.process >= life_k_r));
  assign fire = (phase_s_r >= ivl_k_r);

  always_comb begin
    upd = rec_r;
    upd.process = proc_s_r;
    upd.phase = fire ? (phase_s_r - ivl_k_r) : phase_s_r;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    keep_nxt    = keep_r;
    id_nxt      = id_r;
    ivl_nxt     = ivl_r;
    life_nxt    = life_r;
    unl_nxt     = unl_r;
    el_nxt      = el_r;
    ack_st_nxt  = ack_st_r;
    rec_nxt     = rec_r;
    life_k_nxt  = life_k_r;
    ivl_k_nxt   = ivl_k_r;
    proc_s_nxt  = proc_s_r;
    phase_s_nxt = phase_s_r;
    ov_nxt      = ov_r && out_stall;
    ok_nxt      = ok_r;
    os_nxt      = os_r;
    oid_nxt     = oid_r;
    oel_nxt     = oel_r;
    opr_nxt     = opr_r;
    olast_nxt   = olast_r;
    mem_we      = 1'b0;
    mem_waddr   = keep_r[IDX_W-1:0];
    mem_wdata   = upd;
    mem_raddr   = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          id_nxt     = in_timer_id;
          ivl_nxt    = in_interval_ms;
          life_nxt   = in_life_ms;
          unl_nxt    = in_life_unlimited;
          el_nxt     = (in_elapsed_us < max_el) ? in_elapsed_us : max_el;
          idx_nxt    = '0;
          keep_nxt   = '0;
          ack_st_nxt = ST_OK;
          case (in_cmd)
            CMD_TICK:  state_nxt = S_TRD;
            CMD_START: state_nxt = S_START;
            CMD_STOP:  state_nxt = S_SRD;
            default:   state_nxt = S_ACK;
          endcase
        end
      end
      S_TRD: begin
        state_nxt = (idx_r == count_r) ? S_TEND : S_TMUL;
      end
      S_TMUL: begin
        rec_nxt     = mem_q;
        life_k_nxt  = TIME_W'(mem_q.life) * US_PER_MS;
        ivl_k_nxt   = TIME_W'(mem_q.interval) * US_PER_MS;
        proc_s_nxt  = psum[TIME_W] ? TIME_MAX : psum[TIME_W-1:0];
        phase_s_nxt = hsum[TIME_W] ? TIME_MAX : hsum[TIME_W-1:0];
        state_nxt   = S_TEVAL;
      end
      S_TEVAL: begin
        if (drop) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TRD;
        end else if (!fire || out_free) begin
          // The write slot never passes the read pointer, so no hazard exists.
          mem_we    = 1'b1;
          keep_nxt  = keep_r + 1'b1;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TRD;
          if (fire) begin
            ov_nxt    = 1'b1;
            ok_nxt    = KIND_FIRE;
            os_nxt    = ST_OK;
            oid_nxt   = rec_r.id;
            oel_nxt   = el_r;
            opr_nxt   = proc_s_r;
            olast_nxt = 1'b0;
          end
        end
      end
      S_TEND: begin
        if (out_free) begin
          count_nxt = keep_r;
          ov_nxt    = 1'b1;
          ok_nxt    = KIND_END;
          os_nxt    = ST_OK;
          oid_nxt   = 32'd0;
          oel_nxt   = el_r;
          opr_nxt   = '0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_START: begin
        if (count_r >= CNT_W'(NUM_ENTRIES)) begin
          ack_st_nxt = ST_FULL;
        end else begin
          mem_we              = 1'b1;
          mem_waddr           = count_r[IDX_W-1:0];
          mem_wdata.id        = id_r;
          mem_wdata.interval  = ivl_r;
          mem_wdata.life      = life_r;
          mem_wdata.unlimited = unl_r;
          mem_wdata.stop_flag = 1'b0;
          mem_wdata.process   = '0;
          mem_wdata.phase     = '0;
          count_nxt           = count_r + 1'b1;
        end
        state_nxt = S_ACK;
      end
      S_SRD: begin
        if (idx_r == count_r) begin
          ack_st_nxt = ST_NOT_FOUND;
          state_nxt  = S_ACK;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (mem_q.id == id_r) begin
          mem_we              = 1'b1;
          mem_waddr           = idx_r[IDX_W-1:0];
          mem_wdata           = mem_q;
          mem_wdata.stop_flag = 1'b1;
          state_nxt           = S_ACK;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_ACK: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ok_nxt    = KIND_ACK;
          os_nxt    = ack_st_r;
          oid_nxt   = 32'd0;
          oel_nxt   = 32'd0;
          opr_nxt   = '0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      keep_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      keep_r  <= keep_nxt;
      ov_r    <= ov_nxt;
    end
    id_r      <= id_nxt;
    ivl_r     <= ivl_nxt;
    life_r    <= life_nxt;
    unl_r     <= unl_nxt;
    el_r      <= el_nxt;
    ack_st_r  <= ack_st_nxt;
    rec_r     <= rec_nxt;
    life_k_r  <= life_k_nxt;
    ivl_k_r   <= ivl_k_nxt;
    proc_s_r  <= proc_s_nxt;
    phase_s_r <= phase_s_nxt;
    ok_r      <= ok_nxt;
    os_r      <= os_nxt;
    oid_r     <= oid_nxt;
    oel_r     <= oel_nxt;
    opr_r     <= opr_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid              = ov_r;
  assign out_kind               = ok_r;
  assign out_status             = os_r;
  assign out_fired_id           = oid_r;
  assign out_clamped_elapsed_us = oel_r;
  assign out_process_us         = opr_r;
  assign out_last               = olast_r;

  // The fill count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_ENTRIES))
    else $error("entry count exceeds table size");

  // Compaction never writes past the entry being read.
  a_keep_le_idx: assert property (@(posedge clk) disable iff (!rst_n)
    keep_r <= idx_r)
    else $error("compaction pointer passed read pointer");

  // An accepted transaction makes the block busy in the next cycle.
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after acceptance");

  // The RAM is written only while a command is in progress.
  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE))
    else $error("entry RAM written while idle");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the periodic action timer table.
`timescale 1ns / 1ps

module tb_top;
  import ptt_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 80;

  // One input transaction as the driver presents it.
  typedef struct {
    cmd_t        cmd;
    logic [31:0] timer_id;
    logic [31:0] interval_ms;
    logic [31:0] life_ms;
    logic        unlimited;
    logic [31:0] elapsed_us;
  } timer_cmd_t;

  // One result transaction.
  typedef struct {
    kind_t       kind;
    status_t     status;
    logic [31:0] fired_id;
    logic [31:0] clamped;
    logic [47:0] process;
    logic        last;
  } timer_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [31:0] in_timer_id = '0;
  logic [31:0] in_interval_ms = '0;
  logic [31:0] in_life_ms = '0;
  logic        in_life_unlimited = 1'b0;
  logic [31:0] in_elapsed_us = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [1:0]  out_status;
  logic [31:0] out_fired_id;
  logic [31:0] out_clamped_elapsed_us;
  logic [47:0] out_process_us;
  logic        out_last;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  periodic_action_timer_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_timer_id(in_timer_id), .in_interval_ms(in_interval_ms),
    .in_life_ms(in_life_ms), .in_life_unlimited(in_life_unlimited),
    .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_status(out_status), .out_fired_id(out_fired_id),
    .out_clamped_elapsed_us(out_clamped_elapsed_us),
    .out_process_us(out_process_us), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the table, kept in insertion order like the block.
  logic [31:0] clamp_limit;
  logic        tbl_valid[NUM_ENTRIES];
  logic [31:0] tbl_id[NUM_ENTRIES];
  logic [31:0] tbl_interval[NUM_ENTRIES];
  logic [31:0] tbl_life[NUM_ENTRIES];
  logic        tbl_unlim[NUM_ENTRIES];
  logic        tbl_stopped[NUM_ENTRIES];
  logic [47:0] tbl_process[NUM_ENTRIES];
  logic [47:0] tbl_phase[NUM_ENTRIES];
  int          live_count;

  timer_cmd_t   pending_cmds[$];
  timer_event_t expected_events[$];

  int  sender_idle_pct = 0;
  int  receiver_idle_pct = 0;
  bit  failed = 1'b0;
  int  cycle_count = 0;
  int  accepted_count = 0;
  int  queued_count = 0;

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? TIME_MAX : s[47:0];
  endfunction

  function automatic timer_event_t make_event(kind_t k, status_t s, logic [31:0] id,
                                               logic [31:0] e, logic [47:0] p, logic l);
    timer_event_t ev;
    ev.kind = k; ev.status = s; ev.fired_id = id; ev.clamped = e;
    ev.process = p; ev.last = l;
    return ev;
  endfunction

  // Applies one command to the shadow table and queues the events it causes.
  task automatic predict_timer_events(timer_cmd_t c);
    logic [31:0] e;
    int keep;
    bit found;
    if (c.cmd == CMD_TICK) begin
      e = (c.elapsed_us < clamp_limit) ? c.elapsed_us : clamp_limit;
      keep = 0;
      for (int i = 0; i < live_count; i++) begin
        if (!tbl_valid[i] || tbl_stopped[i]) continue;
        if (!tbl_unlim[i] && (tbl_process[i] / US_PER_MS) >= 48'(tbl_life[i])) continue;
        tbl_process[i] = sat_add(tbl_process[i], e);
        tbl_phase[i] = sat_add(tbl_phase[i], e);
        if ((tbl_phase[i] / US_PER_MS) >= 48'(tbl_interval[i])) begin
          tbl_phase[i] = tbl_phase[i] - 48'(tbl_interval[i]) * US_PER_MS;
          expected_events.push_back(make_event(KIND_FIRE, ST_OK, tbl_id[i], e,
                                               tbl_process[i], 1'b0));
        end
        if (keep != i) begin
          tbl_valid[keep] = tbl_valid[i]; tbl_id[keep] = tbl_id[i];
          tbl_interval[keep] = tbl_interval[i]; tbl_life[keep] = tbl_life[i];
          tbl_unlim[keep] = tbl_unlim[i]; tbl_stopped[keep] = tbl_stopped[i];
          tbl_process[keep] = tbl_process[i]; tbl_phase[keep] = tbl_phase[i];
        end
        keep++;
      end
      for (int i = keep; i < NUM_ENTRIES; i++) tbl_valid[i] = 1'b0;
      live_count = keep;
      expected_events.push_back(make_event(KIND_END, ST_OK, '0, e, '0, 1'b1));
    end else if (c.cmd == CMD_START) begin
      if (live_count >= NUM_ENTRIES) begin
        expected_events.push_back(make_event(KIND_ACK, ST_FULL, '0, '0, '0, 1'b1));
      end else begin
        tbl_valid[live_count] = 1'b1; tbl_id[live_count] = c.timer_id;
        tbl_interval[live_count] = c.interval_ms; tbl_life[live_count] = c.life_ms;
        tbl_unlim[live_count] = c.unlimited; tbl_stopped[live_count] = 1'b0;
        tbl_process[live_count] = '0; tbl_phase[live_count] = '0;
        live_count++;
        expected_events.push_back(make_event(KIND_ACK, ST_OK, '0, '0, '0, 1'b1));
      end
    end else if (c.cmd == CMD_STOP) begin
      found = 1'b0;
      for (int i = 0; i < live_count && !found; i++) begin
        if (tbl_valid[i] && tbl_id[i] == c.timer_id) begin
          tbl_stopped[i] = 1'b1;
          found = 1'b1;
        end
      end
      expected_events.push_back(make_event(KIND_ACK, found ? ST_OK : ST_NOT_FOUND,
                                           '0, '0, '0, 1'b1));
    end else begin
      // The unused command code only gets a plain acknowledge.
      expected_events.push_back(make_event(KIND_ACK, ST_OK, '0, '0, '0, 1'b1));
    end
  endtask

  // Driver: presents the next queued command; the payload holds while stalled,
  // and each accepted transaction is handed to the predictor at once.
  always @(posedge clk) begin
    timer_cmd_t nxt;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_timer_events(pending_cmds.pop_front());
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        // Which command comes next depends on whether the head was just taken.
        if (in_valid && !in_stall ? pending_cmds.size() > 0 : pending_cmds.size() > 0)
        begin
          if ($urandom_range(99) >= sender_idle_pct) begin
            nxt = pending_cmds[0];
            in_valid <= 1'b1;
            in_cmd <= nxt.cmd; in_timer_id <= nxt.timer_id;
            in_interval_ms <= nxt.interval_ms; in_life_ms <= nxt.life_ms;
            in_life_unlimited <= nxt.unlimited; in_elapsed_us <= nxt.elapsed_us;
          end else begin
            in_valid <= 1'b0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    timer_event_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t unexpected result: kind %0d status %0d id %h", $time,
                   out_kind, out_status, out_fired_id);
          failed = 1'b1;
        end else begin
          want = expected_events.pop_front();
          if (out_kind !== want.kind || out_status !== want.status ||
              out_fired_id !== want.fired_id || out_clamped_elapsed_us !== want.clamped ||
              out_process_us !== want.process || out_last !== want.last) begin
            $display("%0t mismatch: expected kind %0d st %0d id %h el %h proc %h last %0d",
                     $time, want.kind, want.status, want.fired_id, want.clamped,
                     want.process, want.last);
            $display("%0t           actual   kind %0d st %0d id %h el %h proc %h last %0d",
                     $time, out_kind, out_status, out_fired_id, out_clamped_elapsed_us,
                     out_process_us, out_last);
            failed = 1'b1;
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[periodic_action_timer_table] ERROR");
      $finish;
    end
  end

  function automatic timer_cmd_t mk(cmd_t c, logic [31:0] id, logic [31:0] iv,
                                    logic [31:0] lf, logic un, logic [31:0] el);
    timer_cmd_t t;
    t.cmd = c; t.timer_id = id; t.interval_ms = iv; t.life_ms = lf;
    t.unlimited = un; t.elapsed_us = el;
    return t;
  endfunction

  task automatic queue_cmd(timer_cmd_t t);
    pending_cmds.push_back(t);
    queued_count++;
  endtask

  // Waits until every queued command is taken and every result has come,
  // then lets the block finish any trailing work.
  task automatic drain;
    while (accepted_count < queued_count || expected_events.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write over the configuration port: setup then access.
  task automatic write_clamp(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    clamp_limit = value;
  endtask

  // Random command: mostly ticks and starts, the starts with small intervals and lifetimes so that
  // entries fire and expire, mixed with stops of ids from a small set and the unused code.
  task automatic queue_random_cmd;
    int pick;
    logic [31:0] id;
    pick = $urandom_range(99);
    id = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(7));
    if (pick < 45) begin
      queue_cmd(mk(CMD_TICK, $urandom, $urandom, $urandom, $urandom_range(1),
                   ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(4000))));
    end else if (pick < 80) begin
      queue_cmd(mk(CMD_START, id,
                   ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(6)),
                   ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(20)),
                   $urandom_range(1), $urandom));
    end else if (pick < 96) begin
      queue_cmd(mk(CMD_STOP, id, $urandom, $urandom, $urandom_range(1), $urandom));
    end else begin
      queue_cmd(mk(cmd_t'(2'd3), $urandom, $urandom, $urandom, $urandom_range(1), $urandom));
    end
  endtask

  initial begin
    clamp_limit = 32'hFFFF_FFFF;
    live_count = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0; tbl_id[i] = '0; tbl_interval[i] = '0; tbl_life[i] = '0;
      tbl_unlim[i] = 1'b0; tbl_stopped[i] = 1'b0; tbl_process[i] = '0; tbl_phase[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset clamp: extremes, zero life and interval,
    // stop handling, the unused code and a full table.
    sender_idle_pct = 17; receiver_idle_pct = 79;
    queue_cmd(mk(CMD_TICK, '0, '0, '0, 1'b0, 32'hFFFF_FFFF));
    queue_cmd(mk(CMD_STOP, 32'hDEAD_BEEF, '0, '0, 1'b0, '0));
    queue_cmd(mk(CMD_START, 32'hFFFF_FFFF, '0, '0, 1'b0, '0));
    queue_cmd(mk(CMD_START, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    queue_cmd(mk(CMD_START, 32'h5, 32'd1, 32'd3, 1'b0, '0));
    queue_cmd(mk(CMD_TICK, '0, '0, '0, 1'b0, 32'd1500));
    queue_cmd(mk(CMD_STOP, 32'h5, '0, '0, 1'b0, '0));
    queue_cmd(mk(CMD_STOP, 32'h5, '0, '0, 1'b0, '0));
    queue_cmd(mk(cmd_t'(2'd3), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                 32'hFFFF_FFFF));
    queue_cmd(mk(CMD_TICK, '0, '0, '0, 1'b1, 32'hFFFF_FFFF));
    for (int i = 0; i < 16; i++)
      queue_cmd(mk(CMD_START, 32'(i + 100), 32'($urandom_range(2)), 32'd4, i[0], '0));
    queue_cmd(mk(CMD_START, 32'h77, '0, '0, 1'b0, '0));
    queue_cmd(mk(CMD_TICK, '0, '0, '0, 1'b0, 32'd1000));
    drain();

    // Smallest clamp: every tick is held to zero.
    write_clamp(32'h0);
    for (int i = 0; i < 24; i++) queue_random_cmd();
    drain();

    // A moderate clamp with the idle roles swapped.
    sender_idle_pct = 79; receiver_idle_pct = 17;
    write_clamp(32'd2500);
    for (int i = 0; i < 24; i++) queue_random_cmd();
    drain();

    // Back to the largest clamp with no idling at all.
    sender_idle_pct = 0; receiver_idle_pct = 0;
    write_clamp(32'hFFFF_FFFF);
    for (int i = 0; i < 24; i++) queue_random_cmd();
    drain();

    if (!failed) begin
      $display("[periodic_action_timer_table] OK");
    end else begin
      $display("[periodic_action_timer_table] ERROR");
    end
    $finish;
  end

endmodule
